// ----- design/hndl_pkg.sv -----
// ----------------------------------------------------------------------------
// Hashed name directory package
// Shared types, command and status codes, and byte helpers for the
// directory lookup unit and its hash engine.
// ----------------------------------------------------------------------------
package hndl_pkg;

    localparam int NAME_W     = 64;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int INDEX_W    = 12;
    localparam int HASH_W     = 16;
    localparam int NAME_BYTES = 8;
    localparam int STEP_W     = $clog2(NAME_BYTES);
    localparam int HASH_SHIFT = 5;

    localparam logic [HASH_W-1:0] HASH_SEED = 16'd5381;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [NAME_W-1:0] entry_name;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  entry_index;
    } rsp_t;

    typedef struct packed {
        logic              start;
        logic [NAME_W-1:0] name;
    } hash_req_t;

    typedef struct packed {
        logic              done;
        logic [HASH_W-1:0] value;
    } hash_rsp_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_HASH,
        ST_HEAD,
        ST_CHECK,
        ST_RESP
    } state_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
        begin
            r = c - CASE_OFFSET;
        end
        return r;
    endfunction

    // Case-insensitive compare that stops at the first NUL.
    function automatic logic names_equal(input logic [NAME_W-1:0] a,
                                         input logic [NAME_W-1:0] b);
        logic [7:0] ca;
        logic [7:0] cb;
        logic       live;
        logic       eq;
        live = 1'b1;
        eq   = 1'b1;
        for (int i = 0; i < NAME_BYTES; i++)
        begin
            ca = fold_byte(a[8*i +: 8]);
            cb = fold_byte(b[8*i +: 8]);
            if (live)
            begin
                if (ca != cb)
                begin
                    eq   = 1'b0;
                    live = 1'b0;
                end
                else if (ca == CHAR_NUL)
                begin
                    live = 1'b0;
                end
            end
        end
        return eq;
    endfunction

endpackage

// ----- design/hndl_hash.sv -----
// ----------------------------------------------------------------------------
// Name hash engine
// Folds one name byte per cycle into a shift-xor hash, stopping at the
// first NUL. Steps through all eight bytes of every name, then a one-cycle done pulse.
// ----------------------------------------------------------------------------
module hndl_hash (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hndl_pkg::hash_req_t   hash_req,
    output hndl_pkg::hash_rsp_t   hash_rsp
);
    import hndl_pkg::*;

    logic [NAME_W-1:0] shift_reg;
    logic [NAME_W-1:0] shift_next;
    logic [HASH_W-1:0] value_reg;
    logic [HASH_W-1:0] value_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              stop_reg;
    logic              stop_next;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [7:0]        folded;
    logic              last_step;

    assign folded    = fold_byte(shift_reg[7:0]);
    assign last_step = (step_reg == STEP_W'(NAME_BYTES - 1));

    always_comb
    begin
        shift_next = shift_reg;
        value_next = value_reg;
        step_next  = step_reg;
        stop_next  = stop_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (hash_req.start)
        begin
            shift_next = hash_req.name;
            value_next = HASH_SEED;
            step_next  = '0;
            stop_next  = 1'b0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            shift_next = shift_reg >> 8;
            step_next  = step_reg + STEP_W'(1);
            if (!stop_reg)
            begin
                if (folded == CHAR_NUL)
                begin
                    stop_next = 1'b1;
                end
                else
                begin
                    value_next = (value_reg << HASH_SHIFT) ^ value_reg
                                 ^ HASH_W'(folded);
                end
            end
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            stop_reg <= 1'b0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            stop_reg <= stop_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        value_reg <= value_next;
    end

    assign hash_rsp.done  = done_reg;
    assign hash_rsp.value = value_reg;

endmodule

// ----- design/hashed_name_directory_lookup_unit.sv -----
// ----------------------------------------------------------------------------
// Hashed name directory lookup unit
// Stores 8-byte names at consecutive indices in bucket chains and finds
// them again by a case-insensitive hashed lookup.
// ----------------------------------------------------------------------------
//  Channel   Valid       Stall       Payload              Beat
//  request   req_valid   req_stall   req_data (req_t)     cmd, entry_name
//  response  rsp_valid   rsp_stall   rsp_data (rsp_t)     status, entry_index
//
//  One command is handled at a time; req_stall is high until it is finished.
//  Insert runs the name through the byte-serial hash engine, then does the
//  bucket head read and write and the response. Lookup does the same hash
//  and head read, then one entry memory read per chain entry visited. Clear
//  writes one bucket head per cycle, then gives its response.
//  After reset the unit empties all bucket heads before it accepts a request.
//  A result waiting in the response register holds the next one back only.
// ----------------------------------------------------------------------------
module hashed_name_directory_lookup_unit #(
    parameter int ENTRIES = 4096,
    parameter int BUCKETS = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  hndl_pkg::req_t  req_data,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output hndl_pkg::rsp_t  rsp_data
);
    import hndl_pkg::*;

    localparam int ADDR_W  = $clog2(ENTRIES);
    localparam int PTR_W   = $clog2(ENTRIES + 1);
    localparam int BIDX_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int ENTRY_W = NAME_W + PTR_W;

    logic [ENTRY_W-1:0] entry_mem [ENTRIES];
    logic [PTR_W-1:0]   head_mem  [BUCKETS];

    state_t             state_reg;
    state_t             state_next;
    logic [CMD_W-1:0]   cmd_reg;
    logic [CMD_W-1:0]   cmd_next;
    logic [NAME_W-1:0]  name_reg;
    logic [NAME_W-1:0]  name_next;
    logic [PTR_W-1:0]   count_reg;
    logic [PTR_W-1:0]   count_next;
    logic [PTR_W-1:0]   ptr_reg;
    logic [PTR_W-1:0]   ptr_next;
    logic [BIDX_W-1:0]  clr_reg;
    logic [BIDX_W-1:0]  clr_next;
    rsp_t               res_reg;
    rsp_t               res_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    rsp_t               rsp_data_reg;
    rsp_t               rsp_data_next;
    logic [PTR_W-1:0]   head_rd_reg;
    logic [ENTRY_W-1:0] entry_rd_reg;

    hash_req_t          hash_req;
    hash_rsp_t          hash_rsp;

    logic               req_accept;
    logic               rsp_free;
    logic               table_full;
    logic               clr_last;
    logic               name_match;
    logic [BIDX_W-1:0]  bucket;
    logic [NAME_W-1:0]  entry_rd_name;
    logic [PTR_W-1:0]   entry_rd_link;

    logic               head_we;
    logic [BIDX_W-1:0]  head_waddr;
    logic [PTR_W-1:0]   head_wdata;
    logic               entry_we;
    logic [ADDR_W-1:0]  entry_waddr;
    logic [ENTRY_W-1:0] entry_wdata;
    logic [ADDR_W-1:0]  entry_raddr;

    hndl_hash u_hash (
        .clk      (clk),
        .rst_n    (rst_n),
        .hash_req (hash_req),
        .hash_rsp (hash_rsp)
    );

    assign req_stall     = (state_reg != ST_IDLE);
    assign req_accept    = req_valid && !req_stall;
    assign rsp_free      = !rsp_valid_reg || !rsp_stall;
    assign table_full    = (count_reg == PTR_W'(ENTRIES));
    assign clr_last      = (clr_reg == BIDX_W'(BUCKETS - 1));
    assign bucket        = BIDX_W'(hash_rsp.value % BUCKETS);
    assign entry_rd_name = entry_rd_reg[ENTRY_W-1:PTR_W];
    assign entry_rd_link = entry_rd_reg[PTR_W-1:0];
    assign name_match    = names_equal(entry_rd_name, name_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    priority if (req_data.cmd == CMD_CLEAR)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else if (req_data.cmd == CMD_INSERT && !table_full)
                    begin
                        state_next = ST_HASH;
                    end
                    else if (req_data.cmd == CMD_LOOKUP)
                    begin
                        state_next = ST_HASH;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_HASH:
            begin
                if (hash_rsp.done)
                begin
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD:
            begin
                if (cmd_reg == CMD_INSERT || head_rd_reg == '0)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (name_match || entry_rd_link == '0)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_next       = cmd_reg;
        name_next      = name_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        clr_next       = clr_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_data_next  = rsp_data_reg;
        hash_req.start = 1'b0;
        hash_req.name  = req_data.entry_name;
        head_we        = 1'b0;
        head_waddr     = bucket;
        head_wdata     = '0;
        entry_we       = 1'b0;
        entry_waddr    = ADDR_W'(count_reg);
        entry_wdata    = {name_reg, head_rd_reg};
        entry_raddr    = '0;
        unique case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                head_we    = 1'b1;
                head_waddr = clr_reg;
                clr_next   = clr_reg + BIDX_W'(1);
                count_next = '0;
                res_next   = '{status: STATUS_OK, entry_index: '0};
            end
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    cmd_next  = req_data.cmd;
                    name_next = req_data.entry_name;
                    clr_next  = '0;
                    res_next  = '{status: STATUS_MISS, entry_index: '0};
                    if (req_data.cmd == CMD_INSERT && table_full)
                    begin
                        res_next = '{status: STATUS_FULL, entry_index: '0};
                    end
                    hash_req.start = (req_data.cmd == CMD_LOOKUP)
                                     || (req_data.cmd == CMD_INSERT && !table_full);
                end
            end
            ST_HASH:
            begin
            end
            ST_HEAD:
            begin
                if (cmd_reg == CMD_INSERT)
                begin
                    entry_we   = 1'b1;
                    head_we    = 1'b1;
                    head_wdata = count_reg + PTR_W'(1);
                    count_next = count_reg + PTR_W'(1);
                    res_next   = '{status: STATUS_OK, entry_index: INDEX_W'(count_reg)};
                end
                else
                begin
                    ptr_next    = head_rd_reg;
                    entry_raddr = ADDR_W'(head_rd_reg - PTR_W'(1));
                end
            end
            ST_CHECK:
            begin
                if (name_match)
                begin
                    res_next = '{status: STATUS_OK,
                                 entry_index: INDEX_W'(ptr_reg - PTR_W'(1))};
                end
                else if (entry_rd_link != '0)
                begin
                    ptr_next    = entry_rd_link;
                    entry_raddr = ADDR_W'(entry_rd_link - PTR_W'(1));
                end
            end
            ST_RESP:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = res_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            count_reg     <= '0;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        name_reg     <= name_next;
        ptr_reg      <= ptr_next;
        res_reg      <= res_next;
        rsp_data_reg <= rsp_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_waddr] <= head_wdata;
        end
        head_rd_reg <= head_mem[bucket];
    end

    always_ff @(posedge clk)
    begin
        if (entry_we)
        begin
            entry_mem[entry_waddr] <= entry_wdata;
        end
        entry_rd_reg <= entry_mem[entry_raddr];
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule
